// File: rtl/gidt_pkg.sv
`timescale 1ns / 1ps
package gidt_pkg;

  localparam int TableDepth = 16;
  localparam int NameBytes  = 8;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW       = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    CMD_ADD       = 2'd0,
    CMD_REMOVE    = 2'd1,
    CMD_FIND_ID   = 2'd2,
    CMD_FIND_NAME = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_INVALID   = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] group_id;
    logic [63:0] name_bytes;
    logic [3:0]  name_len;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] entry_id;
    logic [63:0] entry_name;
    logic [3:0]  entry_len;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [63:0] name;
    logic [3:0]  len;
  } entry_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } ram_wr_t;

  // lengths above the name size saturate
  function automatic logic [3:0] clamp_len(input logic [3:0] len);
    logic [3:0] lim;
    lim = 4'(NameBytes);
    return (len > lim) ? lim : len;
  endfunction

  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < len) begin
        m[b*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

// File: rtl/gidt_mem.sv
`timescale 1ns / 1ps
module gidt_mem (
  input  logic                           clk_i,
  input  gidt_pkg::ram_wr_t              wr_i,
  input  logic [gidt_pkg::IdxW-1:0]      rd_addr_i,
  output gidt_pkg::entry_t               rd_data_o
);

  gidt_pkg::entry_t mem_q [gidt_pkg::TableDepth];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// File: rtl/group_id_table.sv
`timescale 1ns / 1ps
// Ordered group table: entries of {16-bit id, name of up to 8 bytes, length}.
// Input channel (in_valid_i / in_stall_o) carries one command beat; output
// channel (out_valid_o / out_stall_i) returns exactly one result beat per
// command. Commands are handled one at a time.
// Every command walks the table memory in order, one entry per cycle, through
// its registered read port. Add may take two passes (id, then name). A remove
// that hits then moves each later entry up by one, one per cycle.
// in_stall_o is high from acceptance until the result is loaded into the
// output register; the result then waits there while out_stall_i is high, and
// the next command may be accepted meanwhile. A finished result that finds
// the output register still full waits in the block until it is taken.
// Reset empties the table (entry count to zero); entry contents are not
// cleared and are never read before written.
module group_id_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  gidt_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output gidt_pkg::out_t  out_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_e;

  state_e                      state_q, state_d;
  gidt_pkg::in_t               key_q, key_d;
  logic                        by_name_q, by_name_d;
  logic [gidt_pkg::CntW-1:0]   scan_q, scan_d;
  logic [gidt_pkg::CntW-1:0]   used_q, used_d;
  logic [gidt_pkg::IdxW-1:0]   chk_q, chk_d;
  logic                        pend_q, pend_d;
  gidt_pkg::out_t              res_q, res_d;
  gidt_pkg::out_t              out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  gidt_pkg::ram_wr_t           ram_wr;
  logic [gidt_pkg::IdxW-1:0]   ram_raddr;
  gidt_pkg::entry_t            ram_rdata;

  logic                        id_hit, name_hit, hit;

  gidt_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  assign id_hit   = (ram_rdata.id == key_q.group_id);
  assign name_hit = (((ram_rdata.name ^ key_q.name_bytes)
                     & gidt_pkg::byte_mask(ram_rdata.len)) == 64'd0);
  assign hit      = by_name_q ? name_hit : id_hit;

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    by_name_d   = by_name_q;
    scan_d      = scan_q;
    used_d      = used_q;
    chk_d       = chk_q;
    pend_d      = pend_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_wr      = '0;
    ram_raddr   = scan_q[gidt_pkg::IdxW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d          = in_data_i;
          key_d.name_len = gidt_pkg::clamp_len(in_data_i.name_len);
          by_name_d      = (gidt_pkg::cmd_e'(in_data_i.command) == gidt_pkg::CMD_FIND_NAME);
          scan_d         = '0;
          pend_d         = 1'b0;
          state_d        = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (pend_q && hit) begin
          res_d   = '0;
          state_d = ST_RESP;
          unique case (gidt_pkg::cmd_e'(key_q.command))
            gidt_pkg::CMD_ADD: begin
              ram_wr.en      = 1'b1;
              ram_wr.addr    = chk_q;
              ram_wr.data.id = key_q.group_id;
              if (by_name_q) begin
                ram_wr.data.name = ram_rdata.name;
                ram_wr.data.len  = ram_rdata.len;
              end else begin
                ram_wr.data.name = key_q.name_bytes & gidt_pkg::byte_mask(key_q.name_len);
                ram_wr.data.len  = key_q.name_len;
              end
              res_d.status = gidt_pkg::STS_OK;
            end
            gidt_pkg::CMD_REMOVE: begin
              if (name_hit) begin
                scan_d  = gidt_pkg::CntW'(chk_q) + 1'b1;
                pend_d  = 1'b0;
                state_d = ST_SHIFT;
              end else begin
                res_d.status = gidt_pkg::STS_INVALID;
              end
            end
            default: begin
              res_d.status     = gidt_pkg::STS_OK;
              res_d.entry_id   = ram_rdata.id;
              res_d.entry_name = ram_rdata.name & gidt_pkg::byte_mask(ram_rdata.len);
              res_d.entry_len  = ram_rdata.len;
            end
          endcase
        end else if (!pend_q && (scan_q >= used_q)) begin
          res_d   = '0;
          state_d = ST_RESP;
          unique case (gidt_pkg::cmd_e'(key_q.command))
            gidt_pkg::CMD_ADD: begin
              if (!by_name_q) begin
                // no id match: second pass by name
                by_name_d = 1'b1;
                scan_d    = '0;
                state_d   = ST_SCAN;
              end else if (used_q < gidt_pkg::CntW'(gidt_pkg::TableDepth)) begin
                ram_wr.en        = 1'b1;
                ram_wr.addr      = used_q[gidt_pkg::IdxW-1:0];
                ram_wr.data.id   = key_q.group_id;
                ram_wr.data.name = key_q.name_bytes & gidt_pkg::byte_mask(key_q.name_len);
                ram_wr.data.len  = key_q.name_len;
                used_d           = used_q + 1'b1;
                res_d.status     = gidt_pkg::STS_OK;
              end else begin
                res_d.status = gidt_pkg::STS_FULL;
              end
            end
            gidt_pkg::CMD_REMOVE: res_d.status = gidt_pkg::STS_INVALID;
            default:              res_d.status = gidt_pkg::STS_NOT_FOUND;
          endcase
        end else if (scan_q < used_q) begin
          pend_d = 1'b1;
          chk_d  = scan_q[gidt_pkg::IdxW-1:0];
          scan_d = scan_q + 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end

      ST_SHIFT: begin
        // read entry j+1, write it to j in the next cycle
        if (pend_q) begin
          ram_wr.en   = 1'b1;
          ram_wr.addr = chk_q;
          ram_wr.data = ram_rdata;
        end
        if (scan_q < used_q) begin
          pend_d = 1'b1;
          chk_d  = gidt_pkg::IdxW'(scan_q - 1'b1);
          scan_d = scan_q + 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            used_d       = used_q - 1'b1;
            res_d        = '0;
            res_d.status = gidt_pkg::STS_OK;
            state_d      = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    by_name_q <= by_name_d;
    scan_q    <= scan_d;
    chk_q     <= chk_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/gidt_checker.sv
`timescale 1ns / 1ps
module gidt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input gidt_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input gidt_pkg::out_t out_data_o
);

  // a held result beat stays up until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // one command in flight: an accepted beat closes the input
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a command is in flight");

  // entry fields carry data only on a successful lookup
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != gidt_pkg::STS_OK) |->
      (out_data_o.entry_id == 16'd0) && (out_data_o.entry_name == 64'd0) &&
      (out_data_o.entry_len == 4'd0))
    else $error("nonzero entry fields on a failed command");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.entry_len <= 4'(gidt_pkg::NameBytes)) &&
      ((out_data_o.entry_name & ~gidt_pkg::byte_mask(out_data_o.entry_len)) == 64'd0))
    else $error("entry name or length out of range");

  logic unused_in;
  assign unused_in = ^in_data_i;

endmodule

bind group_id_table gidt_checker u_gidt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
